>>> src/urb_pkg.sv
// Shared package for the UART ring buffer block.
// Holds operation codes, the byte width and the queue control and status types.
// No dependencies.
package urb_pkg;

	localparam int unsigned BYTE_W = 8;

	// Operation codes carried on func. The fourth code means nothing and is a no-op.
	localparam logic [1:0] FUNC_WRITE   = 2'd0;
	localparam logic [1:0] FUNC_READ    = 2'd1;
	localparam logic [1:0] FUNC_SERVICE = 2'd2;

	typedef logic [BYTE_W-1:0] byte_t;

	// Per-cycle command to one queue: at most one of push or pop is set.
	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_sts_t;

endpackage

>>> src/urb_cell.sv
// One storage cell of a shifting queue: holds one byte.
// Depends on urb_pkg for the byte type.
module urb_cell
	import urb_pkg::*;
(
	input  logic  clk,
	input  logic  shift,
	input  logic  load,
	input  byte_t load_data,
	input  byte_t next_data,
	output byte_t data
);

	byte_t data_q;

	// A pop moves every byte one place toward the head; a push lands in the
	// first free cell only. The two never happen together on one queue.
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= next_data;
		end else if (load) begin
			data_q <= load_data;
		end
	end

	assign data = data_q;

endmodule

>>> src/urb_queue.sv
// Byte queue built as a row of urb_cell cells with the head in cell zero.
// Depends on urb_pkg and urb_cell.
module urb_queue
	import urb_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_ctl_t    ctl,
	input  byte_t         push_data,
	output byte_t         head_data,
	output logic [CW-1:0] count,
	output queue_sts_t    sts
);

	logic [CW-1:0] count_q;
	byte_t         cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		byte_t nbr;
		if (i == DEPTH - 1) begin : g_tail
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end
		urb_cell u_cell (
			.clk       (clk),
			.shift     (ctl.pop),
			.load      (ctl.push && (count_q == CW'(i))),
			.load_data (push_data),
			.next_data (nbr),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign head_data = cell_data[0];
	assign count     = count_q;
	assign sts.full  = (count_q == CW'(DEPTH));
	assign sts.empty = (count_q == '0);

endmodule

>>> src/uart_tx_rx_ring_buffers.sv
// Top level: transmit and receive byte queues between software and a serial port.
// Depends on urb_pkg and urb_queue.
//
//  channel   handshake                  fields
//  --------  -------------------------  ------------------------------------------
//  command   start, busy                func, tx_byte, port_ready, rx_arrived, rx_byte
//  result    result_valid (one cycle)   status, read_data, send_valid, send_byte,
//                                       rx_count
//
// A command is transferred at a rising edge with start high and busy low. busy is
// always low: each queue is a row of cells that shifts or loads in place, so a
// command can be transferred every cycle. Its result is shown in the next cycle,
// one cycle long, marked by result_valid; the receiver cannot stall it.
// Reset (arst_n low) empties both queues; the cell contents are not cleared and are
// never read before they are written.
module uart_tx_rx_ring_buffers
	import urb_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 64,
	localparam int unsigned CW         = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    func,
	input  logic [7:0]    tx_byte,
	input  logic          port_ready,
	input  logic          rx_arrived,
	input  logic [7:0]    rx_byte,
	output logic          result_valid,
	output logic          status,
	output logic [7:0]    read_data,
	output logic          send_valid,
	output logic [7:0]    send_byte,
	output logic [CW-1:0] rx_count
);

	logic          accept;
	queue_ctl_t    tx_ctl, rx_ctl;
	queue_sts_t    tx_sts, rx_sts;
	byte_t         tx_head, rx_head;
	logic [CW-1:0] tx_cnt, rx_cnt;

	logic  result_valid_q;
	logic  status_q;
	byte_t read_data_q;
	logic  send_valid_q;
	byte_t send_byte_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Command decode. Write fills the transmit tail unless it is full; read takes
	// the receive head unless it is empty; service may do one transmit pop and one
	// receive push in the same cycle, since the two queues are independent.
	always_comb begin
		tx_ctl.push = accept && (func == FUNC_WRITE) && !tx_sts.full;
		tx_ctl.pop  = accept && (func == FUNC_SERVICE) && port_ready && !tx_sts.empty;
		rx_ctl.pop  = accept && (func == FUNC_READ) && !rx_sts.empty;
		rx_ctl.push = accept && (func == FUNC_SERVICE) && rx_arrived && !rx_sts.full;
	end

	urb_queue #(.DEPTH(QUEUE_DEPTH)) u_tx_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (tx_ctl),
		.push_data (tx_byte),
		.head_data (tx_head),
		.count     (tx_cnt),
		.sts       (tx_sts)
	);

	urb_queue #(.DEPTH(QUEUE_DEPTH)) u_rx_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rx_ctl),
		.push_data (rx_byte),
		.head_data (rx_head),
		.count     (rx_cnt),
		.sts       (rx_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= accept;
		end
	end

	// Result payload. Fields that mean nothing for the operation read as zero.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= ((func == FUNC_WRITE) && tx_sts.full) ||
			                ((func == FUNC_READ) && rx_sts.empty);
			read_data_q  <= rx_ctl.pop ? rx_head : '0;
			send_valid_q <= tx_ctl.pop;
			send_byte_q  <= tx_ctl.pop ? tx_head : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign read_data    = read_data_q;
	assign send_valid   = send_valid_q;
	assign send_byte    = send_byte_q;
	// The receive count changes only at the edge that transfers a command, so during
	// the result cycle it is the count after that command.
	assign rx_count     = rx_cnt;

	// Every transferred command yields exactly one result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("result missing after a command transfer");

	a_rx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_cnt <= CW'(QUEUE_DEPTH)) && (tx_cnt <= CW'(QUEUE_DEPTH)))
		else $error("queue count beyond depth");

	a_rx_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		rx_ctl.push |=> (rx_cnt == $past(rx_cnt) + CW'(1)))
		else $error("receive count did not follow a push");

	// The payload holds its last value between results, so only a marked result
	// cycle is checked.
	a_send_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && send_valid) |-> !status)
		else $error("send in a result that reports a failure");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the UART transmit and receive ring buffers.
// Drives commands, predicts each result with a queue model and compares field by field.
// Depends on urb_pkg and the uart_tx_rx_ring_buffers RTL.
`timescale 1ns / 100ps

module tb_top;
	import urb_pkg::*;

	localparam int unsigned DEPTH    = 64;
	localparam int unsigned CW       = $clog2(DEPTH + 1);
	localparam int unsigned CLK_HALF = 4;

	// One command as it is transferred on the command channel.
	typedef struct {
		logic [1:0] func;
		byte_t      tx_byte;
		logic       port_ready;
		logic       rx_arrived;
		byte_t      rx_byte;
	} ring_cmd_t;

	// One result as it appears on the result channel.
	typedef struct {
		logic          status;
		byte_t         read_data;
		logic          send_valid;
		byte_t         send_byte;
		logic [CW-1:0] rx_count;
	} ring_res_t;

	// Traffic flavors for the random part. Filling pushes both queues toward full,
	// draining empties them, mixed is uniform.
	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [1:0]    func;
	logic [7:0]    tx_byte;
	logic          port_ready;
	logic          rx_arrived;
	logic [7:0]    rx_byte;
	logic          result_valid;
	logic          status;
	logic [7:0]    read_data;
	logic          send_valid;
	logic [7:0]    send_byte;
	logic [CW-1:0] rx_count;

	// Model of the two queues: the SV queues hold the bytes in order, oldest first.
	byte_t     tx_model[$];
	byte_t     rx_model[$];
	// Results predicted for transferred commands that have not been seen yet.
	ring_res_t pending_results[$];
	int        error_count;

	uart_tx_rx_ring_buffers #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.tx_byte     (tx_byte),
		.port_ready  (port_ready),
		.rx_arrived  (rx_arrived),
		.rx_byte     (rx_byte),
		.result_valid(result_valid),
		.status      (status),
		.read_data   (read_data),
		.send_valid  (send_valid),
		.send_byte   (send_byte),
		.rx_count    (rx_count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Predicts the result of one command and advances the queue model. Fields
	// that mean nothing for the operation stay zero in the result.
	function automatic ring_res_t predict_ring(input ring_cmd_t c);
		ring_res_t r;
		r = '{status: 1'b0, read_data: '0, send_valid: 1'b0, send_byte: '0, rx_count: '0};
		case (c.func)
			FUNC_WRITE: begin
				// A full transmit queue refuses the byte.
				if (tx_model.size() < DEPTH)
					tx_model.push_back(c.tx_byte);
				else
					r.status = 1'b1;
			end
			FUNC_READ: begin
				// An empty receive queue answers zero and flags it.
				if (rx_model.size() > 0)
					r.read_data = rx_model.pop_front();
				else
					r.status = 1'b1;
			end
			FUNC_SERVICE: begin
				// The transmit hand-off is decided first; the arrival is stored
				// after it and dropped without notice when the queue is full.
				if (c.port_ready && tx_model.size() > 0) begin
					r.send_valid = 1'b1;
					r.send_byte  = tx_model.pop_front();
				end
				if (c.rx_arrived && rx_model.size() < DEPTH)
					rx_model.push_back(c.rx_byte);
			end
			default: begin
				// The unused code leaves the state alone.
			end
		endcase
		r.rx_count = CW'(rx_model.size());
		return r;
	endfunction

	function automatic ring_cmd_t make_cmd(input logic [1:0] f, input byte_t txb,
			input logic pr, input logic ra, input byte_t rxb);
		ring_cmd_t c;
		c.func       = f;
		c.tx_byte    = txb;
		c.port_ready = pr;
		c.rx_arrived = ra;
		c.rx_byte    = rxb;
		return c;
	endfunction

	// Draws one random command. The mode biases the operation mix and the port
	// flags so that long runs reach full and empty queues on both sides.
	function automatic ring_cmd_t random_cmd(input traffic_mode_t mode);
		ring_cmd_t c;
		int unsigned roll;
		roll = $urandom_range(99);
		c = make_cmd(2'($urandom_range(3)), byte_t'($urandom), 1'($urandom),
			1'($urandom), byte_t'($urandom));
		case (mode)
			MODE_FILL: begin
				if (roll < 45) begin
					c.func = FUNC_WRITE;
				end else if (roll < 90) begin
					c.func       = FUNC_SERVICE;
					c.rx_arrived = 1'b1;
					c.port_ready = ($urandom_range(99) < 15);
				end else if (roll < 96) begin
					c.func = FUNC_READ;
				end
			end
			MODE_DRAIN: begin
				if (roll < 45) begin
					c.func = FUNC_READ;
				end else if (roll < 90) begin
					c.func       = FUNC_SERVICE;
					c.port_ready = 1'b1;
					c.rx_arrived = ($urandom_range(99) < 15);
				end else if (roll < 96) begin
					c.func = FUNC_WRITE;
				end
			end
			default: begin
				// Mixed traffic keeps the fully random draw, func 3 included.
			end
		endcase
		return c;
	endfunction

	// Puts one command on the bus at the current rising edge and holds it until
	// the transfer. start stays high afterward, so a following command goes out
	// back to back without start dropping in between.
	task automatic send_cmd(input ring_cmd_t c);
		start      <= 1'b1;
		func       <= c.func;
		tx_byte    <= c.tx_byte;
		port_ready <= c.port_ready;
		rx_arrived <= c.rx_arrived;
		rx_byte    <= c.rx_byte;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_ring(c));
	endtask

	// Idles the sender one cycle at a time, each cycle with the given chance, so
	// that on average that share of the cycles carries no command.
	task automatic sender_gap(input int unsigned pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Holds off the sender until every outstanding result has been checked.
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Short directed sequence: empty and nonempty reads, sends with and without
	// a ready port, simultaneous send and arrival, the unused code, byte extremes
	// and fields that the operation must ignore.
	task automatic test_directed();
		send_cmd(make_cmd(FUNC_READ, 8'h00, 1'b0, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_SERVICE, 8'hff, 1'b1, 1'b0, 8'hff));
		send_cmd(make_cmd(2'd3, 8'hff, 1'b1, 1'b1, 8'hff));
		send_cmd(make_cmd(FUNC_WRITE, 8'h00, 1'b1, 1'b1, 8'hff));
		send_cmd(make_cmd(FUNC_WRITE, 8'hff, 1'b0, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_WRITE, 8'ha5, 1'b0, 1'b1, 8'h5a));
		start <= 1'b0;
		repeat (3) @(posedge clk);
		send_cmd(make_cmd(FUNC_SERVICE, 8'h00, 1'b0, 1'b1, 8'hff));
		send_cmd(make_cmd(FUNC_SERVICE, 8'hff, 1'b1, 1'b1, 8'h00));
		send_cmd(make_cmd(FUNC_SERVICE, 8'h00, 1'b1, 1'b0, 8'h5a));
		send_cmd(make_cmd(FUNC_READ, 8'hff, 1'b1, 1'b1, 8'hff));
		send_cmd(make_cmd(FUNC_READ, 8'h00, 1'b0, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_READ, 8'h00, 1'b1, 1'b1, 8'h00));
		send_cmd(make_cmd(FUNC_SERVICE, 8'h00, 1'b1, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_SERVICE, 8'h00, 1'b1, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_WRITE, 8'h3c, 1'b1, 1'b1, 8'hc3));
		send_cmd(make_cmd(FUNC_READ, 8'h7e, 1'b0, 1'b0, 8'h81));
		send_cmd(make_cmd(2'd3, 8'h00, 1'b0, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_SERVICE, 8'h00, 1'b1, 1'b0, 8'h00));
		wait_drained();
	endtask

	// Random traffic in bursts of one mode each, with the sender idling in the
	// given share of cycles; the phase ends with the sender held off until all
	// is checked.
	task automatic test_random_traffic(input int unsigned idle_pct, input int n_items);
		int sent;
		int burst_len;
		traffic_mode_t mode;
		sent = 0;
		while (sent < n_items) begin
			mode      = traffic_mode_t'($urandom_range(2));
			burst_len = $urandom_range(40, 160);
			for (int i = 0; i < burst_len && sent < n_items; i++) begin
				sender_gap(idle_pct);
				send_cmd(random_cmd(mode));
				sent++;
			end
		end
		wait_drained();
	endtask

	// Result checker. Every result is compared with the oldest prediction; a
	// result with nothing predicted is an error of its own.
	always @(posedge clk) begin
		ring_res_t want;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$error("result with no transfer pending: status=%0d read_data=%0h",
					status, read_data);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (read_data !== want.read_data) begin
					$error("read_data: expected %0h, got %0h", want.read_data, read_data);
					error_count++;
				end
				if (send_valid !== want.send_valid) begin
					$error("send_valid: expected %0d, got %0d", want.send_valid, send_valid);
					error_count++;
				end
				if (send_byte !== want.send_byte) begin
					$error("send_byte: expected %0h, got %0h", want.send_byte, send_byte);
					error_count++;
				end
				if (rx_count !== want.rx_count) begin
					$error("rx_count: expected %0d, got %0d", want.rx_count, rx_count);
					error_count++;
				end
			end
		end
	end

	// Main sequence. Reset is held with every input at a known value; then the
	// directed part runs, followed by three random phases: the sender idles
	// rarely, then often, then never.
	initial begin
		error_count = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		func        = FUNC_WRITE;
		tx_byte     = '0;
		port_ready  = 1'b0;
		rx_arrived  = 1'b0;
		rx_byte     = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random_traffic(13, 630);
		test_random_traffic(57, 630);
		test_random_traffic(0, 640);

		// Every prediction has been matched by now; the wait below gives any stray
		// result time to show up before the verdict.
		repeat (4) @(posedge clk);
		if (pending_results.size() == 0 && error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog. The slowest legal run is about 2000 transfers with the sender
	// idle in a bit over half the cycles at worst; the limit here is far longer
	// than that run.
	initial begin
		#(2_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
src/urb_pkg.sv
src/urb_cell.sv
src/urb_queue.sv
src/uart_tx_rx_ring_buffers.sv
tb/sv/tb_top.sv
